>>> design/mftu_pkg.sv
// Package for the motor feedback turn unwrap unit.
// Holds the field widths, the register reset value and the parameter defaults.
// No dependencies.
package mftu_pkg;

	localparam int ID_W    = 11;
	localparam int BYTE_W  = 8;
	localparam int WORD_W  = 16;
	localparam int SLOT_W  = 3;
	localparam int TOTAL_W = 30;

	localparam logic [ID_W-1:0] BASE_ID_RESET = 11'd516;

	localparam int NUM_MOTORS_DEF = 7;
	localparam int FULL_SCALE_DEF = 8192;

endpackage

>>> design/motor_feedback_turn_unwrap.sv
// Top level of the motor feedback turn unwrap unit.
// Depends on mftu_pkg for widths, the register reset value and parameter defaults.
//
// Usage
// The block takes one received feedback frame per input transaction on the
// in_valid/in_ready channel: an 11-bit identifier and seven payload bytes.
// If the identifier lies in base_id+1 to base_id+NUM_MOTORS (compared without
// wrapping), it selects a motor slot. The payload is decoded big-endian into
// the angle, speed, current and temperature, and the slot's angle is unwrapped
// into a turn count and a multi-turn total. Any other identifier gives one
// result with accepted low, all other fields zero, and no change of state.
// Every input transaction gives exactly one output transaction on out_valid/out_ready.
// The frame is captured in an input register; decode, turn update and total
// are done in one pass into the result register, which drives out_valid.
// One frame is taken per cycle while the receiver keeps up; slot state is written
// at the edge that loads the result, so back-to-back frames to a slot see it.
// When the receiver stalls, the result register holds, the input register
// still fills once, and in_ready then falls until the result is taken.
// A cfg transaction writes base_id (cfg_ready is always high) and belongs
// where no frame is in flight.
// Reset clears both stages, sets base_id to 516 and clears every slot's
// previous angle and turn count.
module motor_feedback_turn_unwrap_unit #(
	parameter int NUM_MOTORS = mftu_pkg::NUM_MOTORS_DEF,
	parameter int FULL_SCALE = mftu_pkg::FULL_SCALE_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// Configuration write channel
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic        [mftu_pkg::ID_W-1:0]  cfg_data,
	// Input frame channel
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic        [mftu_pkg::ID_W-1:0]  frame_id,
	input  logic        [mftu_pkg::BYTE_W-1:0] byte0,
	input  logic        [mftu_pkg::BYTE_W-1:0] byte1,
	input  logic        [mftu_pkg::BYTE_W-1:0] byte2,
	input  logic        [mftu_pkg::BYTE_W-1:0] byte3,
	input  logic        [mftu_pkg::BYTE_W-1:0] byte4,
	input  logic        [mftu_pkg::BYTE_W-1:0] byte5,
	input  logic        [mftu_pkg::BYTE_W-1:0] byte6,
	// Result channel
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              accepted,
	output logic        [mftu_pkg::SLOT_W-1:0] motor_slot,
	output logic        [mftu_pkg::WORD_W-1:0] encoder_angle,
	output logic signed [mftu_pkg::WORD_W-1:0] speed_rpm,
	output logic signed [mftu_pkg::WORD_W-1:0] torque_current,
	output logic        [mftu_pkg::BYTE_W-1:0] temperature,
	output logic signed [mftu_pkg::WORD_W-1:0] turn_count,
	output logic signed [mftu_pkg::TOTAL_W-1:0] total_angle
);
	import mftu_pkg::*;

	// Width of a slot index into the per-motor state.
	localparam int IDX_W = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;
	// Half of full scale, in the width of an absolute angle difference.
	localparam logic [WORD_W:0] HALF = (WORD_W + 1)'(FULL_SCALE / 2);
	localparam int PROD_W = 2 * WORD_W + 2;

	// Configuration register.
	logic [ID_W-1:0] base_id_q;

	// Per-slot state.
	logic [WORD_W-1:0] prev_angle_q [NUM_MOTORS];
	logic [WORD_W-1:0] turns_q      [NUM_MOTORS];

	// Input register.
	logic              valid_s1;
	logic [ID_W-1:0]   frame_id_s1;
	logic [WORD_W-1:0] angle_s1;
	logic [WORD_W-1:0] speed_s1;
	logic [WORD_W-1:0] current_s1;
	logic [BYTE_W-1:0] temp_s1;

	// Result register.
	logic                      valid_s2;
	logic                      accepted_s2;
	logic [SLOT_W-1:0]         slot_s2;
	logic [WORD_W-1:0]         angle_s2;
	logic [WORD_W-1:0]         speed_s2;
	logic [WORD_W-1:0]         current_s2;
	logic [BYTE_W-1:0]         temp_s2;
	logic [WORD_W-1:0]         turns_s2;
	logic [TOTAL_W-1:0]        total_s2;

	// Handshake.
	logic advance;
	logic update;

	// Decode and unwrap.
	logic [ID_W-1:0]          offset;
	logic [ID_W-1:0]          slot_full;
	logic [IDX_W-1:0]         slot_idx;
	logic                     hit;
	logic [WORD_W-1:0]        prev_angle;
	logic [WORD_W-1:0]        prev_turns;
	logic [WORD_W:0]          angle_diff;
	logic [WORD_W:0]          abs_diff;
	logic                     wrapped;
	logic                     speed_pos;
	logic                     turn_up;
	logic                     turn_down;
	logic [WORD_W-1:0]        new_turns;
	logic signed [PROD_W-1:0] turns_scaled;
	logic signed [PROD_W-1:0] total_full;

	// The result register moves whenever it is empty or being taken; the input
	// register refills whenever its frame moves on.
	assign advance   = !valid_s2 || out_ready;
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;
	assign update    = valid_s1 && advance && hit;

	always_comb begin
		offset    = frame_id_s1 - base_id_q;
		hit       = (frame_id_s1 > base_id_q) && (offset <= ID_W'(NUM_MOTORS));
		slot_full = offset - ID_W'(1);
		slot_idx  = slot_full[IDX_W-1:0];
		if (hit) begin
			prev_angle = prev_angle_q[slot_idx];
			prev_turns = turns_q[slot_idx];
		end else begin
			prev_angle = '0;
			prev_turns = '0;
		end

		angle_diff = {1'b0, prev_angle} - {1'b0, angle_s1};
		abs_diff   = angle_diff[WORD_W] ? (~angle_diff + (WORD_W + 1)'(1)) : angle_diff;
		wrapped    = abs_diff > HALF;
		speed_pos  = !speed_s1[WORD_W-1] && (speed_s1 != '0);
		turn_up    = wrapped && ({1'b0, angle_s1} < HALF) && speed_pos;
		turn_down  = wrapped && ({1'b0, angle_s1} > HALF) && speed_s1[WORD_W-1];

		if (turn_up) begin
			new_turns = prev_turns + WORD_W'(1);
		end else if (turn_down) begin
			new_turns = prev_turns - WORD_W'(1);
		end else begin
			new_turns = prev_turns;
		end

		// Total wraps to the output width, two's complement.
		turns_scaled = $signed({{(PROD_W - WORD_W){new_turns[WORD_W-1]}}, new_turns})
			* $signed(PROD_W'(FULL_SCALE));
		total_full   = turns_scaled + $signed({{(PROD_W - WORD_W){1'b0}}, angle_s1});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_id_q <= BASE_ID_RESET;
		end else if (cfg_valid && cfg_ready) begin
			base_id_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_MOTORS; i++) begin
				prev_angle_q[i] <= '0;
				turns_q[i]      <= '0;
			end
		end else if (update) begin
			for (int i = 0; i < NUM_MOTORS; i++) begin
				if (slot_idx == IDX_W'(i)) begin
					prev_angle_q[i] <= angle_s1;
					turns_q[i]      <= new_turns;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			frame_id_s1 <= frame_id;
			angle_s1    <= {byte0, byte1};
			speed_s1    <= {byte2, byte3};
			current_s1  <= {byte4, byte5};
			temp_s1     <= byte6;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			accepted_s2 <= hit;
			if (hit) begin
				slot_s2    <= slot_full[SLOT_W-1:0];
				angle_s2   <= angle_s1;
				speed_s2   <= speed_s1;
				current_s2 <= current_s1;
				temp_s2    <= temp_s1;
				turns_s2   <= new_turns;
				total_s2   <= total_full[TOTAL_W-1:0];
			end else begin
				slot_s2    <= '0;
				angle_s2   <= '0;
				speed_s2   <= '0;
				current_s2 <= '0;
				temp_s2    <= '0;
				turns_s2   <= '0;
				total_s2   <= '0;
			end
		end
	end

	assign out_valid      = valid_s2;
	assign accepted       = accepted_s2;
	assign motor_slot     = slot_s2;
	assign encoder_angle  = angle_s2;
	assign speed_rpm      = $signed(speed_s2);
	assign torque_current = $signed(current_s2);
	assign temperature    = temp_s2;
	assign turn_count     = $signed(turns_s2);
	assign total_angle    = $signed(total_s2);

	// A rejected frame's result has zero turn count, total, angle and slot.
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !accepted) |-> (turn_count == '0 && total_angle == '0
			&& encoder_angle == '0 && motor_slot == '0))
		else $error("rejected frame produced nonzero fields");

	// An accepted result always names an existing slot.
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && accepted) |-> (32'(motor_slot) < NUM_MOTORS))
		else $error("motor slot out of range");

	// An empty result register never blocks the input side.
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> in_ready)
		else $error("input stalled with empty result register");

	// A frame that leaves the input register lands in the result register.
	a_stage_move: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance) |=> valid_s2)
		else $error("frame lost between stages");

	// Slot 0's state only changes on an accepted frame moving to the result.
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!update |=> ($stable(turns_q[0]) && $stable(prev_angle_q[0])))
		else $error("slot state changed without an accepted frame");

endmodule

>>> test/tb_top.sv
// Self-checking testbench for motor_feedback_turn_unwrap_unit.
// Drives feedback frames and base id writes, predicts every result in place and compares.
// Depends on mftu_pkg and the block's top level only.
module tb_top;
	import mftu_pkg::*;

	localparam int MOTORS       = NUM_MOTORS_DEF;
	localparam int SCALE        = FULL_SCALE_DEF;
	localparam int HALF         = SCALE / 2;
	localparam int LIMIT_CYCLES = 1_000_000;
	localparam int HOLD_CYCLES  = 300;
	localparam int HOLD_AFTER   = 150;
	localparam int DIR_ROWS     = 28;
	localparam int SPIN_PAIRS   = 16;

	// One decoded feedback result, laid out like the result ports.
	typedef struct packed {
		logic                     acc;
		logic [SLOT_W-1:0]        slot;
		logic [WORD_W-1:0]        angle;
		logic signed [WORD_W-1:0] speed;
		logic signed [WORD_W-1:0] current;
		logic [BYTE_W-1:0]        temp;
		logic signed [WORD_W-1:0] turns;
		logic signed [TOTAL_W-1:0] total;
	} feedback_t;

	// One received frame; the payload reads as angle, speed, current, temperature.
	typedef struct packed {
		logic [ID_W-1:0] id;
		logic [55:0]     payload;
	} frame_t;

	typedef enum logic [0:0] {ROW_FRAME, ROW_BASE} row_kind_t;

	typedef struct packed {
		row_kind_t       kind;
		logic [ID_W-1:0] base;
		frame_t          frame;
		logic            typed;
		feedback_t       want;
	} dir_row_t;

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_valid;
	logic                       cfg_ready;
	logic [ID_W-1:0]            cfg_data;
	logic                       in_valid;
	logic                       in_ready;
	logic [ID_W-1:0]            frame_id;
	logic [BYTE_W-1:0]          byte0, byte1, byte2, byte3, byte4, byte5, byte6;
	logic                       out_valid;
	logic                       out_ready;
	logic                       accepted;
	logic [SLOT_W-1:0]          motor_slot;
	logic [WORD_W-1:0]          encoder_angle;
	logic signed [WORD_W-1:0]   speed_rpm;
	logic signed [WORD_W-1:0]   torque_current;
	logic [BYTE_W-1:0]          temperature;
	logic signed [WORD_W-1:0]   turn_count;
	logic signed [TOTAL_W-1:0]  total_angle;

	// Predictor state: the base id register and the per-slot unwrap history.
	logic [ID_W-1:0]            base_reg;
	logic [WORD_W-1:0]          prev_angle [MOTORS];
	logic signed [WORD_W-1:0]   turn_store [MOTORS];

	// Results that the block still owes, oldest first.
	feedback_t                  feedback_q [$];

	// Stimulus state: a smoothly moving angle per slot so that real wraps occur.
	int                         motion_angle [MOTORS];
	int                         burst_left;
	bit                         rush;
	bit                         hold_done;
	int                         failures;
	int                         frames_sent;
	int                         results_seen;
	int                         turn_events;
	int                         cycle_count;
	dir_row_t                   dir_rows [DIR_ROWS];

	motor_feedback_turn_unwrap_unit uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.frame_id       (frame_id),
		.byte0          (byte0),
		.byte1          (byte1),
		.byte2          (byte2),
		.byte3          (byte3),
		.byte4          (byte4),
		.byte5          (byte5),
		.byte6          (byte6),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.accepted       (accepted),
		.motor_slot     (motor_slot),
		.encoder_angle  (encoder_angle),
		.speed_rpm      (speed_rpm),
		.torque_current (torque_current),
		.temperature    (temperature),
		.turn_count     (turn_count),
		.total_angle    (total_angle)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Computes the result of one frame and advances the slot history. A frame whose
	// identifier falls outside base+1 .. base+MOTORS yields an all-zero result and
	// leaves the history alone. The window test is done in int so that it never wraps.
	function automatic feedback_t predict_feedback(frame_t f);
		feedback_t                r;
		int                       slot;
		int                       diff;
		logic [WORD_W-1:0]        ang;
		logic signed [WORD_W-1:0] spd;
		logic signed [WORD_W-1:0] t;
		r = '0;
		if (int'(f.id) < int'(base_reg) + 1 || int'(f.id) > int'(base_reg) + MOTORS)
			return r;
		slot = int'(f.id) - int'(base_reg) - 1;
		ang = f.payload[55:40];
		spd = f.payload[39:24];
		diff = int'(prev_angle[slot]) - int'(ang);
		if (diff < 0)
			diff = -diff;
		t = turn_store[slot];
		// A jump of more than half a turn counts as a wrap only when the speed
		// agrees with the direction; an angle of exactly half a turn never counts.
		if (diff > HALF) begin
			if (int'(ang) < HALF && spd > 0)
				t = t + 16'sd1;
			else if (int'(ang) > HALF && spd < 0)
				t = t - 16'sd1;
		end
		if (t != turn_store[slot])
			turn_events++;
		turn_store[slot] = t;
		prev_angle[slot] = ang;
		r.acc = 1'b1;
		r.slot = slot[SLOT_W-1:0];
		r.angle = ang;
		r.speed = spd;
		r.current = f.payload[23:8];
		r.temp = f.payload[7:0];
		r.turns = t;
		r.total = TOTAL_W'(int'(t) * SCALE + int'(ang));
		return r;
	endfunction

	function automatic frame_t make_frame(logic [ID_W-1:0] id, logic [WORD_W-1:0] ang,
		logic [WORD_W-1:0] spd, logic [WORD_W-1:0] cur, logic [BYTE_W-1:0] temp);
		frame_t f;
		f.id = id;
		f.payload = {ang, spd, cur, temp};
		return f;
	endfunction

	// Mostly no gap, some short gaps, a few long ones, and gap-free bursts.
	function automatic int pick_gap();
		int r;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Most frames hit the window and follow a moving angle whose speed sign matches
	// its direction, so turn counts really climb and fall. The rest are edge
	// identifiers just outside the window, stray identifiers and raw payloads.
	function automatic frame_t random_frame();
		int                r;
		int                slot;
		int                step;
		logic [ID_W-1:0]   id;
		logic [WORD_W-1:0] ang;
		logic [WORD_W-1:0] spd;
		r = $urandom_range(0, 99);
		slot = $urandom_range(0, MOTORS - 1);
		if (r < 85)
			id = ID_W'(int'(base_reg) + 1 + slot);
		else if (r < 93)
			id = $urandom_range(0, 1) ? ID_W'(int'(base_reg) + MOTORS + 1) : base_reg;
		else
			id = ID_W'($urandom_range(0, 2047));
		if ($urandom_range(0, 99) < 70) begin
			step = int'($urandom_range(0, 3000)) - 1500;
			motion_angle[slot] = (motion_angle[slot] + step + SCALE) % SCALE;
			ang = WORD_W'(motion_angle[slot]);
			if (step > 0)
				spd = WORD_W'($urandom_range(1, 32767));
			else if (step < 0)
				spd = WORD_W'(-int'($urandom_range(1, 32768)));
			else
				spd = '0;
		end else begin
			ang = ($urandom_range(0, 3) == 0) ? WORD_W'(HALF) : WORD_W'($urandom);
			spd = WORD_W'($urandom);
		end
		return make_frame(id, ang, spd, WORD_W'($urandom), BYTE_W'($urandom));
	endfunction

	// Offers one frame and holds it until the block takes it. The expectation is
	// queued at the accepting edge; a typed row replaces the predicted value with
	// the one written in the table, while the predictor still advances its history.
	task automatic send_frame(frame_t f, logic typed, feedback_t want);
		feedback_t guess;
		int        gap;
		in_valid <= 1'b1;
		frame_id <= f.id;
		byte0 <= f.payload[55:48];
		byte1 <= f.payload[47:40];
		byte2 <= f.payload[39:32];
		byte3 <= f.payload[31:24];
		byte4 <= f.payload[23:16];
		byte5 <= f.payload[15:8];
		byte6 <= f.payload[7:0];
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		guess = predict_feedback(f);
		feedback_q.push_back(typed ? want : guess);
		frames_sent++;
		gap = rush ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stops offering frames and waits until every owed result has been taken, then
	// idles briefly so that the two-stage pipeline is empty.
	task automatic settle();
		in_valid <= 1'b0;
		while (feedback_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_base(logic [ID_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		base_reg = value;
	endtask

	task automatic run_random(int count);
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 49) == 0)
				burst_left = 30;
			send_frame(random_frame(), 1'b0, '0);
		end
	endtask

	task automatic compare_feedback(feedback_t want);
		if (accepted !== want.acc) begin
			$error("accepted: expected %0d, got %0d", want.acc, accepted);
			failures++;
		end
		if (motor_slot !== want.slot) begin
			$error("motor_slot: expected %0d, got %0d", want.slot, motor_slot);
			failures++;
		end
		if (encoder_angle !== want.angle) begin
			$error("encoder_angle: expected %0d, got %0d", want.angle, encoder_angle);
			failures++;
		end
		if (speed_rpm !== want.speed) begin
			$error("speed_rpm: expected %0d, got %0d", want.speed, speed_rpm);
			failures++;
		end
		if (torque_current !== want.current) begin
			$error("torque_current: expected %0d, got %0d", want.current, torque_current);
			failures++;
		end
		if (temperature !== want.temp) begin
			$error("temperature: expected %0d, got %0d", want.temp, temperature);
			failures++;
		end
		if (turn_count !== want.turns) begin
			$error("turn_count: expected %0d, got %0d", want.turns, turn_count);
			failures++;
		end
		if (total_angle !== want.total) begin
			$error("total_angle: expected %0d, got %0d", want.total, total_angle);
			failures++;
		end
	endtask

	// Result monitor. It samples at the rising edge, where the block's outputs and
	// out_ready still hold the values that decide the transaction.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (feedback_q.size() == 0) begin
				$error("result transaction arrived with nothing expected");
				failures++;
			end else begin
				compare_feedback(feedback_q.pop_front());
			end
		end
	end

	// Receiver. It is ready in runs of random length and stalls between them,
	// mostly briefly and now and then for a long while. Once, after a number of
	// results, it holds off for a long stretch while the sender keeps offering, so
	// that the pipeline fills and in_ready drops. In rush mode it never stalls.
	initial begin : drain_side
		int run;
		int stall;
		out_ready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			out_ready <= 1'b1;
			if (rush)
				run = 1;
			else if ($urandom_range(0, 9) == 0)
				run = $urandom_range(50, 200);
			else
				run = $urandom_range(1, 12);
			repeat (run) @(posedge clk);
			if (!hold_done && results_seen >= HOLD_AFTER) begin
				hold_done = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (!rush) begin
				stall = $urandom_range(0, 99);
				if (stall < 80)
					stall = $urandom_range(1, 2);
				else if (stall < 95)
					stall = $urandom_range(3, 6);
				else
					stall = $urandom_range(10, 40);
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	initial begin : stimulus
		int spin_id;
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		in_valid <= 1'b0;
		frame_id <= '0;
		byte0 <= '0;
		byte1 <= '0;
		byte2 <= '0;
		byte3 <= '0;
		byte4 <= '0;
		byte5 <= '0;
		byte6 <= '0;
		base_reg = BASE_ID_RESET;
		for (int s = 0; s < MOTORS; s++) begin
			prev_angle[s] = '0;
			turn_store[s] = '0;
			motion_angle[s] = 0;
		end

		// Directed rows. Rejected identifiers, the first frame after reset and the
		// all-ones frame carry their result in the table; the others go to the
		// predictor. The rows walk through exact-half angles, jumps with and without
		// a matching speed sign, angles above full scale, the speed and current
		// extremes, and the window at base 0 and at the top of the identifier space.
		dir_rows = '{
			'{ROW_FRAME, 11'd0, '{11'd516, 56'hFFFF_FFFF_FFFF_FF}, 1'b1, '0},
			'{ROW_FRAME, 11'd0, '{11'd524, 56'h1234_5678_9ABC_DE}, 1'b1, '0},
			'{ROW_FRAME, 11'd0, '{11'd517, 56'h0000_0000_0000_00}, 1'b1,
				'{1'b1, 3'd0, 16'd0, 16'sd0, 16'sd0, 8'd0, 16'sd0, 30'sd0}},
			'{ROW_FRAME, 11'd0, '{11'd523, 56'hFFFF_FFFF_FFFF_FF}, 1'b1,
				'{1'b1, 3'd6, 16'hFFFF, -16'sd1, -16'sd1, 8'hFF, -16'sd1, 30'sd57343}},
			'{ROW_FRAME, 11'd0, '{11'd517, 56'h1000_0005_0000_20}, 1'b0, '0},
			'{ROW_FRAME, 11'd0, '{11'd517, 56'h1FFF_0001_0010_21}, 1'b0, '0},
			'{ROW_FRAME, 11'd0, '{11'd517, 56'h0064_7FFF_7FFF_80}, 1'b0, '0},
			'{ROW_FRAME, 11'd0, '{11'd517, 56'h1F40_8000_8000_7F}, 1'b0, '0},
			'{ROW_FRAME, 11'd0, '{11'd517, 56'h0064_FFFD_0001_22}, 1'b0, '0},
			'{ROW_FRAME, 11'd0, '{11'd517, 56'h1F40_0003_FFFE_23}, 1'b0, '0},
			'{ROW_FRAME, 11'd0, '{11'd517, 56'h0064_0000_0000_24}, 1'b0, '0},
			'{ROW_FRAME, 11'd0, '{11'd517, 56'h2328_0001_0100_25}, 1'b0, '0},
			'{ROW_FRAME, 11'd0, '{11'd517, 56'h1000_FFFF_0200_26}, 1'b0, '0},
			'{ROW_FRAME, 11'd0, '{11'd517, 56'hFFFF_0001_0300_27}, 1'b0, '0},
			'{ROW_FRAME, 11'd0, '{11'd517, 56'h1000_0001_0400_28}, 1'b0, '0},
			'{ROW_FRAME, 11'd0, '{11'd518, 56'hA55A_5AA5_A55A_5A}, 1'b0, '0},
			'{ROW_FRAME, 11'd0, '{11'd522, 56'h5AA5_A55A_5AA5_A5}, 1'b0, '0},
			'{ROW_BASE, 11'd0, '0, 1'b0, '0},
			'{ROW_FRAME, 11'd0, '{11'd0, 56'h7777_7777_7777_77}, 1'b1, '0},
			'{ROW_FRAME, 11'd0, '{11'd1, 56'h0800_0100_0040_30}, 1'b0, '0},
			'{ROW_FRAME, 11'd0, '{11'd7, 56'h1800_FF00_FFC0_31}, 1'b0, '0},
			'{ROW_FRAME, 11'd0, '{11'd8, 56'h0001_0001_0001_01}, 1'b1, '0},
			'{ROW_BASE, 11'd2040, '0, 1'b0, '0},
			'{ROW_FRAME, 11'd0, '{11'd2040, 56'hABCD_EF01_2345_67}, 1'b1, '0},
			'{ROW_FRAME, 11'd0, '{11'd2041, 56'h0010_0020_0030_40}, 1'b0, '0},
			'{ROW_FRAME, 11'd0, '{11'd2047, 56'h1FF0_FFE0_FFD0_41}, 1'b0, '0},
			'{ROW_FRAME, 11'd0, '{11'd0, 56'h1111_1111_1111_11}, 1'b1, '0},
			'{ROW_BASE, 11'd516, '0, 1'b0, '0}
		};

		// Reset is held low from the start and released at a rising edge.
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_BASE) begin
				settle();
				set_base(dir_rows[i].base);
			end else begin
				send_frame(dir_rows[i].frame, dir_rows[i].typed, dir_rows[i].want);
			end
		end

		// Random phases under base ids 516, a random value, 2040, 0 and 516 again. The
		// long receiver hold-off falls inside the first one.
		settle();
		run_random(600);
		settle();
		set_base(ID_W'($urandom_range(0, 2040)));
		run_random(450);
		settle();
		set_base(11'd2040);
		run_random(300);
		settle();
		set_base(11'd0);
		run_random(200);
		settle();
		set_base(BASE_ID_RESET);
		run_random(150);

		// Step one slot forward and then back again without any idling, so that
		// back-to-back frames to the same slot carry its turn count up and down.
		settle();
		rush = 1'b1;
		spin_id = int'(base_reg) + 4;
		for (int k = 0; k < SPIN_PAIRS; k++) begin
			send_frame(make_frame(ID_W'(spin_id), 16'd7000, 16'd100, 16'd0, 8'd30), 1'b0, '0);
			send_frame(make_frame(ID_W'(spin_id), 16'd1000, 16'd100, 16'd0, 8'd30), 1'b0, '0);
		end
		for (int k = 0; k < SPIN_PAIRS; k++) begin
			send_frame(make_frame(ID_W'(spin_id), 16'd7000, -16'sd100, 16'd0, 8'd32),
				1'b0, '0);
			send_frame(make_frame(ID_W'(spin_id), 16'd1000, -16'sd100, 16'd0, 8'd32),
				1'b0, '0);
		end

		settle();
		repeat (8) @(posedge clk);
		$display("summary: %0d frames sent, %0d results checked, %0d turn count changes,",
			frames_sent, results_seen, turn_events);
		$display("summary: base ids 0, 516, 2040 and random, long receiver hold, gap-free spin");
		if (failures == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule
